FILE: sv/mfmm_pkg.sv
`default_nettype none

package mfmm_pkg;

  // Default sizing of the stores
  localparam int DIFF_FRAMES_DEF = 4;
  localparam int MAX_PIXELS_DEF  = 65536;

  // Field widths
  localparam int PIX_W  = 8;
  localparam int GREY_W = 8;
  localparam int DIM_W  = 9;
  localparam int THR_W  = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MOTION_THRESHOLD = 2'd2;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST      = 9'd256;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST     = 9'd256;
  localparam logic [THR_W-1:0] MOTION_THRESHOLD_RST = 8'd20;

  // Luma weights, Q14
  localparam int GREY_ACC_W = 23;
  localparam logic [GREY_ACC_W-1:0] COEF_B   = 23'd1868;
  localparam logic [GREY_ACC_W-1:0] COEF_G   = 23'd9617;
  localparam logic [GREY_ACC_W-1:0] COEF_R   = 23'd4899;
  localparam logic [GREY_ACC_W-1:0] GREY_RND = 23'd8192;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_blue;
    logic [PIX_W-1:0] pixel_green;
    logic [PIX_W-1:0] pixel_red;
  } in_item_t;

  typedef struct packed {
    logic motion_flag;
    logic frame_end;
  } out_item_t;

  function automatic logic [GREY_W-1:0] to_grey(input in_item_t px);
    logic [GREY_ACC_W-1:0] acc;
    acc = COEF_B * GREY_ACC_W'(px.pixel_blue)
        + COEF_G * GREY_ACC_W'(px.pixel_green)
        + COEF_R * GREY_ACC_W'(px.pixel_red)
        + GREY_RND;
    return acc[14 +: GREY_W];
  endfunction

endpackage

`default_nettype wire

FILE: sv/multi_frame_motion_mask_top.sv
// Motion mask over a stream of colour pixels in raster order.
// Input channel in_valid/in_stall/in_data: one pixel per transaction.
// Output channel out_valid/out_stall/out_data: one motion flag per pixel, with
// frame_end set on the last pixel of each frame.
// Config port cfg_wr_en/cfg_index/cfg_wr_data: frame width, frame height and
// motion threshold; write only while no pixel is in flight.
// An accepted pixel is registered in stage 1 and then in the output queue before it is offered.
// Throughput: one pixel per clock while in_stall is low. Each pixel costs one
// read and one write of a single row of the pixel store (grey of the last frame
// plus one difference byte per ring slot); a back-to-back pixel on the same row
// takes the row from the write-back register.
// Reset: the stores read as zero after reset. A fill mark tracks how far the
// raster has gone; rows beyond it read as zero, so there is no clearing pass
// and the block takes pixels right after reset.
// Stall: a two-entry output queue absorbs results; in_stall rises only when
// the queue and the pipeline stage would overflow.
`default_nettype none

module multi_frame_motion_mask_top #(
  parameter int DIFF_FRAMES = mfmm_pkg::DIFF_FRAMES_DEF,
  parameter int MAX_PIXELS  = mfmm_pkg::MAX_PIXELS_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire mfmm_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output mfmm_pkg::out_item_t                      out_data,
  input  wire logic                                cfg_wr_en,
  input  wire logic [mfmm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mfmm_pkg::CFG_DATA_W-1:0]     cfg_wr_data
);

  import mfmm_pkg::*;

  localparam int ADDR_W = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int SLOT_W = (DIFF_FRAMES > 1) ? $clog2(DIFF_FRAMES) : 1;
  localparam int ROW_W  = GREY_W * (DIFF_FRAMES + 1);
  localparam int PROD_W = 2 * DIM_W;
  localparam int CMP_W  = ((ADDR_W + 1) > PROD_W) ? (ADDR_W + 1) : PROD_W;
  localparam logic [CMP_W-1:0]  MAX_PIX_C = CMP_W'(MAX_PIXELS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DIFF_FRAMES - 1);

  // Configuration registers
  logic [DIM_W-1:0] frame_width_r;
  logic [DIM_W-1:0] frame_height_r;
  logic [THR_W-1:0] motion_threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r      <= FRAME_WIDTH_RST;
      frame_height_r     <= FRAME_HEIGHT_RST;
      motion_threshold_r <= MOTION_THRESHOLD_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:      frame_width_r      <= cfg_wr_data[DIM_W-1:0];
        CFG_FRAME_HEIGHT:     frame_height_r     <= cfg_wr_data[DIM_W-1:0];
        CFG_MOTION_THRESHOLD: motion_threshold_r <= cfg_wr_data[THR_W-1:0];
        default: ;  // ignore writes beyond the register list
      endcase
    end
  end

  // Front end: raster position, ring slot and fill mark
  logic              in_acc;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [ADDR_W:0]   fill_r, fill_nxt;
  logic [PROD_W-1:0] frame_prod;
  logic [CMP_W-1:0]  frame_size;
  logic              in_last;
  logic              in_hit;

  assign in_acc = in_valid && !in_stall;

  always_comb begin
    frame_prod = PROD_W'(frame_width_r) * PROD_W'(frame_height_r);
    // Empty frame counts as one pixel; clamp to the store size
    if (frame_prod == '0) begin
      frame_size = CMP_W'(1);
    end else if (CMP_W'(frame_prod) > MAX_PIX_C) begin
      frame_size = MAX_PIX_C;
    end else begin
      frame_size = CMP_W'(frame_prod);
    end
    in_last = (CMP_W'(pos_r) + CMP_W'(1)) >= frame_size;
    in_hit  = ({1'b0, pos_r} < fill_r);

    pos_nxt  = pos_r;
    slot_nxt = slot_r;
    fill_nxt = fill_r;
    if (in_acc) begin
      if (in_last) begin
        pos_nxt  = '0;
        slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + SLOT_W'(1);
      end else begin
        pos_nxt  = pos_r + ADDR_W'(1);
      end
      // Advance the fill mark the first time a row is touched
      if (!in_hit) begin
        fill_nxt = fill_r + (ADDR_W + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      slot_r <= '0;
      fill_r <= '0;
    end else begin
      pos_r  <= pos_nxt;
      slot_r <= slot_nxt;
      fill_r <= fill_nxt;
    end
  end

  // Stage 1: row read in flight, grey computed at accept
  logic              s1_vld_r;
  logic [ADDR_W-1:0] s1_pos_r;
  logic [SLOT_W-1:0] s1_slot_r;
  logic [GREY_W-1:0] s1_grey_r;
  logic              s1_hit_r;
  logic              s1_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pos_r  <= pos_r;
      s1_slot_r <= slot_r;
      s1_grey_r <= to_grey(in_data);
      s1_hit_r  <= in_hit;
      s1_last_r <= in_last;
    end
  end

  // Pixel store: one row per position
  logic [ROW_W-1:0] ram_rd_data;
  logic [ROW_W-1:0] row_new;

  mfmm_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_PIXELS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (s1_vld_r),
    .wr_addr (s1_pos_r),
    .wr_data (row_new),
    .rd_en   (in_acc),
    .rd_addr (pos_r),
    .rd_data (ram_rd_data)
  );

  // Write-back register for forwarding the last written row
  logic              wb_vld_r;
  logic [ADDR_W-1:0] wb_pos_r;
  logic [ROW_W-1:0]  wb_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_vld_r <= 1'b0;
    end else if (s1_vld_r) begin
      wb_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_vld_r) begin
      wb_pos_r <= s1_pos_r;
      wb_row_r <= row_new;
    end
  end

  // Modify: difference into the current slot, OR over all slots
  logic [ROW_W-1:0]  row_cur;
  logic [GREY_W-1:0] prev_grey;
  logic [GREY_W-1:0] diff;
  logic [GREY_W-1:0] or_acc;
  logic              s1_flag;

  always_comb begin
    if (wb_vld_r && (wb_pos_r == s1_pos_r)) begin
      row_cur = wb_row_r;
    end else if (s1_hit_r) begin
      row_cur = ram_rd_data;
    end else begin
      row_cur = '0;
    end
    prev_grey = row_cur[GREY_W-1:0];
    diff      = (s1_grey_r > prev_grey) ? (s1_grey_r - prev_grey) : '0;

    row_new[GREY_W-1:0] = s1_grey_r;
    or_acc = '0;
    for (int k = 0; k < DIFF_FRAMES; k++) begin
      if (s1_slot_r == SLOT_W'(k)) begin
        row_new[GREY_W*(k+1) +: GREY_W] = diff;
      end else begin
        row_new[GREY_W*(k+1) +: GREY_W] = row_cur[GREY_W*(k+1) +: GREY_W];
      end
      or_acc = or_acc | row_new[GREY_W*(k+1) +: GREY_W];
    end
    s1_flag = (or_acc > motion_threshold_r);
  end

  // Output queue
  out_item_t  res;
  logic [1:0] q_cnt;
  logic [2:0] in_flight;
  logic       pop;

  assign res.motion_flag = s1_flag;
  assign res.frame_end   = s1_last_r;

  mfmm_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (s1_vld_r),
    .push_data (res),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .count     (q_cnt)
  );

  // Hold input when the pipeline stage plus queue would exceed two entries
  assign pop       = out_valid && !out_stall;
  assign in_flight = 3'(s1_vld_r) + 3'(q_cnt);
  assign in_stall  = (in_flight >= (3'd2 + 3'(pop)));

  // Assertions
  assert property (@(posedge clk) disable iff (!rst_n)
    !(s1_vld_r && (q_cnt == 2'd2) && !pop))
    else $error("output queue overflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, pos_r} <= fill_r) && (fill_r <= (ADDR_W + 1)'(MAX_PIXELS)))
    else $error("raster position ahead of fill mark");

  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_last |=> (pos_r == '0))
    else $error("position not wrapped after last pixel");

  assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !s1_hit_r |-> (s1_pos_r == ADDR_W'(fill_r - (ADDR_W + 1)'(1))))
    else $error("unwritten row read away from fill mark");

endmodule

`default_nettype wire

FILE: sv/mfmm_ram.sv
`default_nettype none

module mfmm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                                  clk,
  input  wire logic                                  wr_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]                      wr_data,
  input  wire logic                                  rd_en,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic      [WIDTH-1:0]                      rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read during write to the same row returns the old contents
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: sv/mfmm_outq.sv
`default_nettype none

module mfmm_outq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire mfmm_pkg::out_item_t push_data,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output mfmm_pkg::out_item_t      out_data,
  output logic [1:0]               count
);

  import mfmm_pkg::*;

  out_item_t  slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot_r[rd_ptr_r];
  assign count     = cnt_r;
  assign pop       = out_valid && !out_stall;

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire
